>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the segment box slab test RTL.
// Included by the modules that check their own pipeline invariants.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define SBST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbst assertion failed");

// Next-cycle implication under an active-low reset.
`define SBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbst assertion failed");

`endif

>>> hw/rtl/sbst_pkg.sv
// Constants for the segment box slab test pipeline.
// No dependencies; imported by the front end and the top level.
package sbst_pkg;

    // Configuration register indexes
    localparam int REG_IDX_BITS = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_BOX_TOP    = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_BOX_HEIGHT = 2'd3;

    // Near-zero test: h^2 * (10^12 - 1) < other^2, with 10^12 = 5^12 * 2^12.
    localparam int            NEAR_POW_BITS  = 28;
    localparam logic [27:0]   NEAR_FIVE_POW  = 28'd244140625;
    localparam int            NEAR_SHIFT     = 12;
    // Components at or above 2^NEAR_MAG_BITS can never be near zero.
    localparam int            NEAR_MAG_BITS  = 12;
    localparam int            NEAR_SQ_BITS   = 2 * NEAR_MAG_BITS;
    localparam int            NEAR_PROD_BITS = NEAR_SQ_BITS + NEAR_POW_BITS;
    localparam int            NEAR_CMP_BITS  = NEAR_PROD_BITS + NEAR_SHIFT + 1;

endpackage

>>> hw/rtl/sbst_front.sv
// Front end of the slab test: slab distances, squares and near-zero flags.
// Three register stages; depends on sbst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbst_front
    import sbst_pkg::*;
#(
    parameter int C = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_ready,
    output logic                  o_valid,
    input  logic signed [C-1:0]   i_origin_x,
    input  logic signed [C-1:0]   i_origin_y,
    input  logic signed [C-1:0]   i_heading_x,
    input  logic signed [C-1:0]   i_heading_y,
    input  logic [C-2:0]          i_reach,
    input  logic signed [C-1:0]   i_box_left,
    input  logic signed [C-1:0]   i_box_top,
    input  logic [C-2:0]          i_box_width,
    input  logic [C-2:0]          i_box_height,
    output logic [2*C-1:0]        o_sum,
    output logic signed [C+1:0]   o_ax,
    output logic signed [C+1:0]   o_bx,
    output logic signed [C+1:0]   o_ay,
    output logic signed [C+1:0]   o_by,
    output logic [C-1:0]          o_ahx,
    output logic [C-1:0]          o_ahy,
    output logic [C-2:0]          o_reach,
    output logic                  o_use_x,
    output logic                  o_use_y,
    output logic                  o_ok
);
    localparam int NW = C + 2;
    localparam int SW = 2 * C;

    logic signed [NW-1:0] w_px, w_py, w_lox, w_hix, w_loy, w_hiy;
    logic [C:0]           w_ahx_full, w_ahy_full;
    logic                 w_rdy1, w_rdy2, w_rdy3;

    // stage 1 registers
    logic                 r_v1;
    logic signed [NW-1:0] r_ax1, r_bx1, r_ay1, r_by1;
    logic [C-1:0]         r_ahx1, r_ahy1;
    logic [SW-1:0]        r_hx2_1, r_hy2_1;
    logic [C-2:0]         r_reach1;
    logic                 r_inx1, r_iny1, r_zero1;

    // stage 2 registers
    logic                      r_v2;
    logic signed [NW-1:0]      r_ax2, r_bx2, r_ay2, r_by2;
    logic [C-1:0]              r_ahx2, r_ahy2;
    logic [SW-1:0]             r_sum2;
    logic [NEAR_PROD_BITS-1:0] r_mx2, r_my2;
    logic                      r_smx2, r_smy2;
    logic [C-2:0]              r_reach2;
    logic                      r_inx2, r_iny2, r_zero2;

    // stage 3 registers
    logic                 r_v3;
    logic signed [NW-1:0] r_ax3, r_bx3, r_ay3, r_by3;
    logic [C-1:0]         r_ahx3, r_ahy3;
    logic [SW-1:0]        r_sum3;
    logic [C-2:0]         r_reach3;
    logic                 r_ux3, r_uy3, r_ok3, r_zero3;

    logic [NEAR_CMP_BITS-1:0] w_lhs_x, w_lhs_y, w_rhs;
    logic                     w_near_x, w_near_y, w_use_x, w_use_y;

    // per-stage ready: a stage moves when empty or when the next one moves
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // extend coordinates and edges to the distance width
    assign w_px  = NW'(i_origin_x);
    assign w_py  = NW'(i_origin_y);
    assign w_lox = NW'(i_box_left);
    assign w_loy = NW'(i_box_top);
    assign w_hix = w_lox + $signed({2'b00, i_box_width});
    assign w_hiy = w_loy + $signed({2'b00, i_box_height});
    assign w_ahx_full = i_heading_x[C-1] ? (C+1)'(-$signed({i_heading_x[C-1], i_heading_x}))
                                         : {1'b0, i_heading_x};
    assign w_ahy_full = i_heading_y[C-1] ? (C+1)'(-$signed({i_heading_y[C-1], i_heading_y}))
                                         : {1'b0, i_heading_y};

    // stage 1: slab distances, magnitudes, squares, origin-in-slab flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_rdy1) begin
            r_ax1    <= i_heading_x[C-1] ? (w_px - w_hix) : (w_lox - w_px);
            r_bx1    <= i_heading_x[C-1] ? (w_px - w_lox) : (w_hix - w_px);
            r_ay1    <= i_heading_y[C-1] ? (w_py - w_hiy) : (w_loy - w_py);
            r_by1    <= i_heading_y[C-1] ? (w_py - w_loy) : (w_hiy - w_py);
            r_ahx1   <= w_ahx_full[C-1:0];
            r_ahy1   <= w_ahy_full[C-1:0];
            r_hx2_1  <= w_ahx_full[C-1:0] * w_ahx_full[C-1:0];
            r_hy2_1  <= w_ahy_full[C-1:0] * w_ahy_full[C-1:0];
            r_reach1 <= i_reach;
            r_inx1   <= !(w_px < w_lox || w_px > w_hix);
            r_iny1   <= !(w_py < w_loy || w_py > w_hiy);
            r_zero1  <= (i_heading_x == '0) && (i_heading_y == '0);
        end
    end

    // stage 2: sum of squares and scaled squares for the near-zero test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2) begin
            r_ax2    <= r_ax1;
            r_bx2    <= r_bx1;
            r_ay2    <= r_ay1;
            r_by2    <= r_by1;
            r_ahx2   <= r_ahx1;
            r_ahy2   <= r_ahy1;
            r_sum2   <= r_hx2_1 + r_hy2_1;
            r_mx2    <= r_hx2_1[NEAR_SQ_BITS-1:0] * NEAR_FIVE_POW;
            r_my2    <= r_hy2_1[NEAR_SQ_BITS-1:0] * NEAR_FIVE_POW;
            r_smx2   <= (r_ahx1 >> NEAR_MAG_BITS) == '0;
            r_smy2   <= (r_ahy1 >> NEAR_MAG_BITS) == '0;
            r_reach2 <= r_reach1;
            r_inx2   <= r_inx1;
            r_iny2   <= r_iny1;
            r_zero2  <= r_zero1;
        end
    end

    // near zero: h^2 * 5^12 * 2^12 < h^2 + other^2
    assign w_lhs_x  = {1'b0, r_mx2, {NEAR_SHIFT{1'b0}}};
    assign w_lhs_y  = {1'b0, r_my2, {NEAR_SHIFT{1'b0}}};
    assign w_rhs    = NEAR_CMP_BITS'(r_sum2);
    assign w_near_x = r_smx2 && (w_lhs_x < w_rhs);
    assign w_near_y = r_smy2 && (w_lhs_y < w_rhs);
    assign w_use_x  = !((r_ahx2 == '0) || w_near_x);
    assign w_use_y  = !((r_ahy2 == '0) || w_near_y);

    // stage 3: axis use flags and the slab-containment verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
        if (w_rdy3) begin
            r_ax3    <= r_ax2;
            r_bx3    <= r_bx2;
            r_ay3    <= r_ay2;
            r_by3    <= r_by2;
            r_ahx3   <= r_ahx2;
            r_ahy3   <= r_ahy2;
            r_sum3   <= r_sum2;
            r_reach3 <= r_reach2;
            r_ux3    <= w_use_x;
            r_uy3    <= w_use_y;
            r_ok3    <= !r_zero2 && (w_use_x || r_inx2) && (w_use_y || r_iny2);
            r_zero3  <= r_zero2;
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum3;
    assign o_ax    = r_ax3;
    assign o_bx    = r_bx3;
    assign o_ay    = r_ay3;
    assign o_by    = r_by3;
    assign o_ahx   = r_ahx3;
    assign o_ahy   = r_ahy3;
    assign o_reach = r_reach3;
    assign o_use_x = r_ux3;
    assign o_use_y = r_uy3;
    assign o_ok    = r_ok3;

    // a zero direction yields a zero square sum and never passes
    `SBST_ASSERT_NEXT(a_zero_sum, i_clk, i_rst_n, r_v1 && w_rdy2 && r_zero1, r_sum2 == '0)
    `SBST_ASSERT_IMPLY(a_zero_miss, i_clk, i_rst_n, r_v3 && r_zero3, !r_ok3)

endmodule

>>> hw/rtl/sbst_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
// Depends on assert_macros.svh; no package content used.
`include "assert_macros.svh"
module sbst_sqrt #(
    parameter int C  = 24,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_ready,
    output logic            o_valid,
    input  logic [2*C-1:0]  i_radicand,
    input  logic [PW-1:0]   i_pay,
    output logic [C-1:0]    o_root,
    output logic [PW-1:0]   o_pay
);
    localparam int RW = 2 * C;

    logic [C-1:0]  r_root [C];
    logic [RW-1:0] r_rem  [C];
    logic [PW-1:0] r_pay  [C];
    logic          r_v    [C];
    logic          w_rdy  [C+1];

    assign w_rdy[C] = i_ready;

    genvar k;
    generate
        for (k = 0; k < C; k++) begin : g_stage
            localparam int BI = C - 1 - k;
            logic [C-1:0]  w_root_in;
            logic [RW-1:0] w_rem_in;
            logic [PW-1:0] w_pay_in;
            logic          w_v_in;
            logic [RW:0]   w_trial;
            logic          w_take;

            if (k == 0) begin : g_first
                assign w_root_in = '0;
                assign w_rem_in  = i_radicand;
                assign w_pay_in  = i_pay;
                assign w_v_in    = i_valid;
            end else begin : g_next
                assign w_root_in = r_root[k-1];
                assign w_rem_in  = r_rem[k-1];
                assign w_pay_in  = r_pay[k-1];
                assign w_v_in    = r_v[k-1];
            end

            // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 4^i
            assign w_trial = ((RW+1)'(w_root_in) << (BI + 1)) + ((RW+1)'(1) << (2 * BI));
            assign w_take  = w_trial <= {1'b0, w_rem_in};
            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

            // advance one bit of the root
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_v[k] <= w_v_in;
                end
                if (w_rdy[k]) begin
                    r_pay[k]  <= w_pay_in;
                    r_root[k] <= w_take ? (w_root_in | (C'(1) << BI)) : w_root_in;
                    r_rem[k]  <= w_take ? (w_rem_in - w_trial[RW-1:0]) : w_rem_in;
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[C-1];
    assign o_root  = r_root[C-1];
    assign o_pay   = r_pay[C-1];

    // floor root leaves a remainder no larger than twice the root
    `SBST_ASSERT_IMPLY(a_sqrt_rem, i_clk, i_rst_n, r_v[C-1],
        {1'b0, r_rem[C-1]} <= ((RW+1)'(r_root[C-1]) << 1))

endmodule

>>> hw/rtl/sbst_decide.sv
// Back end of the slab test: cross products of slab distances and the verdict.
// Two register stages, the second being the output register; no dependencies.
module sbst_decide #(
    parameter int C = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_ready,
    output logic                  o_valid,
    input  logic signed [C+1:0]   i_ax,
    input  logic signed [C+1:0]   i_bx,
    input  logic signed [C+1:0]   i_ay,
    input  logic signed [C+1:0]   i_by,
    input  logic [C-1:0]          i_ahx,
    input  logic [C-1:0]          i_ahy,
    input  logic [C-1:0]          i_mag,
    input  logic [C-2:0]          i_reach,
    input  logic                  i_use_x,
    input  logic                  i_use_y,
    input  logic                  i_ok,
    output logic                  o_hit
);
    localparam int PW = 2 * C + 3;

    logic signed [C:0]    w_mag_s, w_ahx_s, w_ahy_s, w_reach_s;
    logic                 w_rdy1, w_rdy2;

    logic                 r_v1;
    logic signed [PW-1:0] r_ax_mag, r_rx, r_ay_mag, r_ry;
    logic signed [PW-1:0] r_ax_hy, r_by_hx, r_ay_hx, r_bx_hy;
    logic                 r_bx_pos, r_by_pos, r_ux, r_uy, r_ok;

    logic                 r_v2, r_hit2;
    logic                 w_x_ok, w_y_ok, w_cross_ok;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_mag_s   = $signed({1'b0, i_mag});
    assign w_ahx_s   = $signed({1'b0, i_ahx});
    assign w_ahy_s   = $signed({1'b0, i_ahy});
    assign w_reach_s = $signed({2'b00, i_reach});

    // stage 1: compare distances by cross-multiplying over their divisors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_rdy1) begin
            r_ax_mag <= i_ax * w_mag_s;
            r_rx     <= w_reach_s * w_ahx_s;
            r_ay_mag <= i_ay * w_mag_s;
            r_ry     <= w_reach_s * w_ahy_s;
            r_ax_hy  <= i_ax * w_ahy_s;
            r_by_hx  <= i_by * w_ahx_s;
            r_ay_hx  <= i_ay * w_ahx_s;
            r_bx_hy  <= i_bx * w_ahy_s;
            r_bx_pos <= !i_bx[C+1];
            r_by_pos <= !i_by[C+1];
            r_ux     <= i_use_x;
            r_uy     <= i_use_y;
            r_ok     <= i_ok;
        end
    end

    // every entry distance must not exceed any exit distance
    assign w_x_ok     = !r_ux || (r_bx_pos && (r_ax_mag <= r_rx));
    assign w_y_ok     = !r_uy || (r_by_pos && (r_ay_mag <= r_ry));
    assign w_cross_ok = !(r_ux && r_uy) || ((r_ax_hy <= r_by_hx) && (r_ay_hx <= r_bx_hy));

    // stage 2: output register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2) begin
            r_hit2 <= r_ok && w_x_ok && w_y_ok && w_cross_ok;
        end
    end

    assign o_valid = r_v2;
    assign o_hit   = r_hit2;

endmodule

>>> hw/rtl/segment_box_slab_test_top.sv
// Top level of the segment box slab test: configuration registers and pipeline.
// Depends on sbst_pkg, sbst_front, sbst_sqrt, sbst_decide and assert_macros.svh.
//
// Usage:
//   The input channel (i_in_valid / o_in_stall) carries one segment per item:
//   origin, heading and reach, all fixed point. The output channel
//   (o_out_valid / i_out_stall) returns one item per segment holding o_hit,
//   set when the segment meets the rectangle held in the box registers.
//   Box registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write them only while no item is in flight, which the block does
//   not enforce; they reset to zero. The pipeline holds three front stages, one
//   square-root stage per root bit, one multiply stage and the output register.
//   Throughput is one item per cycle while the receiver does not stall; the
//   square-root chain of COORD_BITS stages sets the depth.
//   Reset empties every stage. When the receiver stalls, the result holds in
//   the output register and the pipeline keeps filling its bubbles; the input
//   stalls only once every stage holds an item.
`include "assert_macros.svh"
module segment_box_slab_test_top
    import sbst_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_BITS-1:0]  i_origin_x,
    input  logic signed [COORD_BITS-1:0]  i_origin_y,
    input  logic signed [COORD_BITS-1:0]  i_heading_x,
    input  logic signed [COORD_BITS-1:0]  i_heading_y,
    input  logic [COORD_BITS-2:0]         i_reach,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    input  logic                          i_cfg_we,
    input  logic [REG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [COORD_BITS-1:0]         i_cfg_data
);
    localparam int C  = COORD_BITS;
    localparam int NW = C + 2;
    localparam int PW = 4 * NW + 2 * C + (C - 1) + 3;

    logic signed [C-1:0] r_box_left, r_box_top;
    logic [C-2:0]        r_box_width, r_box_height;

    logic                 w_f_rdy, w_f_v, w_s_rdy, w_s_v, w_d_rdy;
    logic [2*C-1:0]       w_sum;
    logic signed [NW-1:0] w_ax, w_bx, w_ay, w_by;
    logic [C-1:0]         w_ahx, w_ahy, w_mag;
    logic [C-2:0]         w_reach;
    logic                 w_ux, w_uy, w_ok;
    logic [PW-1:0]        w_pay_in, w_pay_out;

    logic signed [NW-1:0] w_ax_d, w_bx_d, w_ay_d, w_by_d;
    logic [C-1:0]         w_ahx_d, w_ahy_d;
    logic [C-2:0]         w_reach_d;
    logic                 w_ux_d, w_uy_d, w_ok_d;

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_width  <= '0;
            r_box_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_LEFT:   r_box_left   <= i_cfg_data;
                REG_BOX_TOP:    r_box_top    <= i_cfg_data;
                REG_BOX_WIDTH:  r_box_width  <= i_cfg_data[C-2:0];
                REG_BOX_HEIGHT: r_box_height <= i_cfg_data[C-2:0];
                default: ;
            endcase
        end
    end

    sbst_front #(.C(C)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (w_f_rdy),
        .i_ready      (w_s_rdy),
        .o_valid      (w_f_v),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_heading_x  (i_heading_x),
        .i_heading_y  (i_heading_y),
        .i_reach      (i_reach),
        .i_box_left   (r_box_left),
        .i_box_top    (r_box_top),
        .i_box_width  (r_box_width),
        .i_box_height (r_box_height),
        .o_sum        (w_sum),
        .o_ax         (w_ax),
        .o_bx         (w_bx),
        .o_ay         (w_ay),
        .o_by         (w_by),
        .o_ahx        (w_ahx),
        .o_ahy        (w_ahy),
        .o_reach      (w_reach),
        .o_use_x      (w_ux),
        .o_use_y      (w_uy),
        .o_ok         (w_ok)
    );

    // carry the slab terms alongside the root
    assign w_pay_in = {w_ax, w_bx, w_ay, w_by, w_ahx, w_ahy, w_reach, w_ux, w_uy, w_ok};
    assign {w_ax_d, w_bx_d, w_ay_d, w_by_d, w_ahx_d, w_ahy_d, w_reach_d,
            w_ux_d, w_uy_d, w_ok_d} = w_pay_out;

    sbst_sqrt #(.C(C), .PW(PW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_f_v),
        .o_ready    (w_s_rdy),
        .i_ready    (w_d_rdy),
        .o_valid    (w_s_v),
        .i_radicand (w_sum),
        .i_pay      (w_pay_in),
        .o_root     (w_mag),
        .o_pay      (w_pay_out)
    );

    sbst_decide #(.C(C)) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s_v),
        .o_ready  (w_d_rdy),
        .i_ready  (!i_out_stall),
        .o_valid  (o_out_valid),
        .i_ax     (w_ax_d),
        .i_bx     (w_bx_d),
        .i_ay     (w_ay_d),
        .i_by     (w_by_d),
        .i_ahx    (w_ahx_d),
        .i_ahy    (w_ahy_d),
        .i_mag    (w_mag),
        .i_reach  (w_reach_d),
        .i_use_x  (w_ux_d),
        .i_use_y  (w_uy_d),
        .i_ok     (w_ok_d),
        .o_hit    (o_hit)
    );

    assign o_in_stall = !w_f_rdy;

    // input backs up only behind a stalled, full output
    `SBST_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // a used axis always has a nonzero root to scale reach with
    `SBST_ASSERT_IMPLY(a_mag_nonzero, i_clk, i_rst_n, w_s_v && (w_ux_d || w_uy_d), w_mag != '0)

endmodule

>>> test/segment_box_slab_test_top_tb.sv
// Self-checking testbench for segment_box_slab_test_top: segments against a box.
// Depends on sbst_pkg and the RTL; predicts each hit with an exact slab test.
module segment_box_slab_test_top_tb;
    import sbst_pkg::*;

    localparam int CW = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned NEAR_LIMIT = 64'd999999999999;

    typedef struct {
        logic signed [CW-1:0] ox, oy, hx, hy;
        logic [CW-2:0]        reach;
        bit                   known;
        bit                   hit;
    } t_segment;

    logic                 i_clk, i_rst_n;
    logic                 i_in_valid, o_in_stall;
    logic signed [CW-1:0] i_origin_x, i_origin_y, i_heading_x, i_heading_y;
    logic [CW-2:0]        i_reach;
    logic                 o_out_valid, i_out_stall, o_hit;
    logic                 i_cfg_we;
    logic [REG_IDX_BITS-1:0] i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;

    // Box registers as the predictor sees them
    longint box_x, box_y, box_w, box_h;

    bit     hit_queue[$];
    int     errors;
    bit     hold_request;
    bit     idle_out;

    segment_box_slab_test_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // One axis of the slab test; distances are n*mag/d with d > 0.
    function automatic bit slab_pass(input longint p, input longint h, input longint lo,
                                     input longint size, input longint unsigned h2,
                                     input longint unsigned other2,
                                     inout longint tmin_n, inout longint tmin_d,
                                     inout longint tmax_n, inout longint tmax_d);
        longint hi, n1, n2, d, an, bn;
        bit     near;
        hi = lo + size;
        near = (other2 > 0) && (h2 <= (other2 - 1) / NEAR_LIMIT);
        if (h == 0 || near) return !(p < lo || p > hi);
        n1 = lo - p;
        n2 = hi - p;
        if (h < 0) begin
            n1 = -n1;
            n2 = -n2;
        end
        d = (h < 0) ? -h : h;
        an = (n1 <= n2) ? n1 : n2;
        bn = (n1 <= n2) ? n2 : n1;
        if (an * tmin_d > tmin_n * d) begin
            tmin_n = an;
            tmin_d = d;
        end
        if (bn * tmax_d < tmax_n * d) begin
            tmax_n = bn;
            tmax_d = d;
        end
        return tmin_n * tmax_d <= tmax_n * tmin_d;
    endfunction

    function automatic bit predict_hit(input t_segment s);
        longint ox, oy, hx, hy, mag, tmin_n, tmin_d, tmax_n, tmax_d;
        longint unsigned hx2, hy2;
        ox = s.ox;
        oy = s.oy;
        hx = s.hx;
        hy = s.hy;
        if (hx == 0 && hy == 0) return 1'b0;
        hx2 = hx * hx;
        hy2 = hy * hy;
        mag = floor_root(hx2 + hy2);
        if (mag == 0) mag = 1;
        tmin_n = 0;
        tmin_d = 1;
        tmax_n = s.reach;
        tmax_d = mag;
        if (!slab_pass(ox, hx, box_x, box_w, hx2, hy2, tmin_n, tmin_d, tmax_n, tmax_d))
            return 1'b0;
        return slab_pass(oy, hy, box_y, box_h, hy2, hx2, tmin_n, tmin_d, tmax_n, tmax_d);
    endfunction

    // Write one register; the caller drops the write enable after the last one
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [CW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_BOX_LEFT:   box_x = longint'($signed(data));
            REG_BOX_TOP:    box_y = longint'($signed(data));
            REG_BOX_WIDTH:  box_w = data[CW-2:0];
            REG_BOX_HEIGHT: box_h = data[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [CW-1:0] x, input logic [CW-1:0] y,
                           input logic [CW-1:0] w, input logic [CW-1:0] h);
        write_reg(REG_BOX_LEFT, x);
        write_reg(REG_BOX_TOP, y);
        write_reg(REG_BOX_WIDTH, w);
        write_reg(REG_BOX_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one segment after a gap; queue its hit once accepted
    task automatic send_segment(input t_segment s, input int gap);
        bit taken;
        bit want;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_origin_x  <= s.ox;
        i_origin_y  <= s.oy;
        i_heading_x <= s.hx;
        i_heading_y <= s.hy;
        i_reach     <= s.reach;
        want = predict_hit(s);
        if (s.known && s.hit != want) begin
            $display("%0t table row hit expected %0b predictor %0b", $time, s.hit, want);
            errors++;
        end
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        hit_queue.push_back(s.known ? s.hit : want);
    endtask

    // Drop the input, then wait for every queued item to come out
    task automatic drain;
        i_in_valid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pick a coordinate near one box edge, or anywhere
    function automatic logic [CW-1:0] near_box(input longint lo, input longint size);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return lo + $urandom_range(0, 3) - 1;
            2: return lo + size + $urandom_range(0, 3) - 1;
            default: return lo + longint'($urandom_range(0, 4096)) - 1024;
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_heading;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 0;
            2: return $urandom_range(0, 16) - 8;
            3: return longint'($urandom_range(0, 8192)) - 4096;
            4: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return longint'($urandom_range(0, 1024)) - 512;
        endcase
    endfunction

    function automatic t_segment rand_segment;
        t_segment s;
        s.ox = near_box(box_x, box_w);
        s.oy = near_box(box_y, box_h);
        s.hx = rand_heading();
        s.hy = rand_heading();
        case ($urandom_range(0, 3))
            0: s.reach = $urandom;
            1: s.reach = 0;
            2: s.reach = $urandom_range(0, 1) ? 23'h7FFFFF : 23'd1;
            default: s.reach = $urandom_range(0, 8192);
        endcase
        s.known = 1'b0;
        s.hit = 1'b0;
        return s;
    endfunction

    // Result side: random stall, long hold on request, check each item
    initial begin
        int  wait_n;
        bit  got, val;
        bit  want;
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            wait_n = idle_out ? $urandom_range(0, 12) : 0;
            if (hold_request) begin
                wait_n = 300;
                hold_request = 1'b0;
            end
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got = o_out_valid;
                val = o_hit;
                @(posedge i_clk);
            end while (!got);
            if (hit_queue.size() == 0) begin
                $display("%0t unexpected item, expected none, actual hit %0b", $time, val);
                errors++;
            end else begin
                want = hit_queue.pop_front();
                if (want !== val) begin
                    $display("%0t hit mismatch expected %0b actual %0b", $time, want, val);
                    errors++;
                end
            end
        end
    end

    // Directed rows against a 10 x 10 box at the origin
    t_segment rows[] = '{
        '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'd100, 1'b1, 1'b0},
        '{24'sd256, 24'sd256, 24'sd256, 24'sd0, 23'd0, 1'b1, 1'b1},
        '{-24'sd256, 24'sd256, 24'sd256, 24'sd0, 23'd0, 1'b1, 1'b0},
        '{-24'sd256, 24'sd512, 24'sd256, 24'sd0, 23'd512, 1'b1, 1'b1},
        '{-24'sd256, 24'sd512, 24'sd256, 24'sd0, 23'd255, 1'b1, 1'b0},
        '{-24'sd256, 24'sd512, 24'sd256, 24'sd0, 23'd256, 1'b1, 1'b1},
        '{24'sd3072, 24'sd512, -24'sd256, 24'sd0, 23'd512, 1'b1, 1'b1},
        '{24'sd512, 24'sd3072, 24'sd0, -24'sd256, 23'd512, 1'b1, 1'b1},
        '{24'sd512, -24'sd256, 24'sd0, 24'sd256, 23'd100, 1'b1, 1'b0},
        '{24'sd2560, 24'sd2560, 24'sd256, 24'sd256, 23'd0, 1'b1, 1'b1},
        '{24'sd3000, 24'sd512, 24'sd256, 24'sd0, 23'h7FFFFF, 1'b1, 1'b0},
        '{24'sd512, -24'sd512, 24'sd1, 24'sh7FFFFF, 23'h7FFFFF, 1'b0, 1'b0},
        '{-24'sd512, 24'sd512, 24'sh7FFFFF, -24'sd1, 23'h7FFFFF, 1'b0, 1'b0},
        '{-24'sd512, 24'sd3000, 24'sh7FFFFF, 24'sd2, 23'h7FFFFF, 1'b0, 1'b0},
        '{24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 1'b0, 1'b0},
        '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 23'h7FFFFF, 1'b0, 1'b0},
        '{24'sh800000, 24'sd512, 24'sh7FFFFF, 24'sd0, 23'h7FFFFF, 1'b0, 1'b0},
        '{-24'sd256, -24'sd256, 24'sd256, 24'sd256, 23'd400, 1'b0, 1'b0},
        '{-24'sd256, -24'sd256, 24'sd256, 24'sd256, 23'd300, 1'b0, 1'b0},
        '{24'sd1280, 24'sd1280, 24'sh800000, 24'sd3, 23'd1, 1'b0, 1'b0}
    };

    // Stimulus: reset, directed table, then random phases over box settings
    initial begin
        t_segment s;
        logic [CW-1:0] boxes[7][4];
        errors = 0;
        hold_request = 1'b0;
        idle_out = 1'b1;
        box_x = 0;
        box_y = 0;
        box_w = 0;
        box_h = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_origin_x = '0;
        i_origin_y = '0;
        i_heading_x = '0;
        i_heading_y = '0;
        i_reach = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_BOX_LEFT;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset box is a single point at the origin
        s = '{24'sd0, 24'sd0, 24'sd256, 24'sd0, 23'd0, 1'b1, 1'b1};
        send_segment(s, 0);
        drain();

        set_box(24'd0, 24'd0, 24'd2560, 24'd2560);
        foreach (rows[k]) send_segment(rows[k], $urandom_range(0, 3));
        drain();

        boxes = '{
            '{24'hFFF000, 24'h000800, 24'h001000, 24'h000400},
            '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF},
            '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF},
            '{24'h000100, 24'hFFFF00, 24'h000000, 24'h000000},
            '{24'hFFFE00, 24'hFFFE00, 24'h000400, 24'h000400},
            '{24'h123456, 24'hF0F0F0, 24'h00F00F, 24'h000FFF},
            '{24'h000000, 24'h000000, 24'h000A00, 24'h000A00}
        };
        foreach (boxes[p]) begin
            set_box(boxes[p][0], boxes[p][1], boxes[p][2], boxes[p][3]);
            idle_out = (p % 3) != 2;
            if (p == 4) hold_request = 1'b1;
            for (int k = 0; k < 200; k++) begin
                s = rand_segment();
                if (p == 4 && k < 80) send_segment(s, 0);
                else send_segment(s, ((p % 3) == 1) ? 0 : $urandom_range(0, 12));
            end
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            drain();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
